/* sv/pls_pkg.sv */
// Shared types and constants of the piecewise linear sensor scaler.
`default_nettype none

package pls_pkg;

   // Fixed field widths of the request and response payloads.
   localparam int RAW_W = 10;
   localparam int SCL_W = 32;
   localparam int IDX_W = 3;

   // Default number of breakpoints.
   localparam int BIN_COUNT_DEF = 8;

   // Widths of the serial datapath: slope difference, product, final sum.
   localparam int DIFF_W = SCL_W + 1;
   localparam int PROD_W = DIFF_W + RAW_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int CNT_W  = $clog2(PROD_W);

   typedef logic        [RAW_W-1:0] raw_type;
   typedef logic signed [SCL_W-1:0] scaled_type;
   typedef logic        [IDX_W-1:0] index_type;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_CONVERT = 1'b1
   } opcode_type;

   // One breakpoint as it is held in the table memory.
   typedef struct packed {
      raw_type    raw;
      scaled_type scaled;
   } entry_type;

   localparam scaled_type SCL_MAX = {1'b0, {(SCL_W-1){1'b1}}};
   localparam scaled_type SCL_MIN = {1'b1, {(SCL_W-1){1'b0}}};

endpackage

`default_nettype wire

/* sv/pls_if.sv */
// Request and response channel interfaces of the piecewise linear sensor scaler.
`default_nettype none

interface pls_req_if;
   import pls_pkg::*;

   logic       valid;
   logic       ready;
   opcode_type opcode;
   index_type  entry_index;
   raw_type    raw_point;
   scaled_type scaled_point;
   raw_type    sample;

   modport source (output valid, opcode, entry_index, raw_point, scaled_point, sample,
                   input ready);
   modport sink   (input valid, opcode, entry_index, raw_point, scaled_point, sample,
                   output ready);
endinterface

interface pls_rsp_if;
   import pls_pkg::*;

   logic       valid;
   logic       ready;
   scaled_type scaled_value;
   logic       saturated;

   modport source (output valid, scaled_value, saturated, input ready);
   modport sink   (input valid, scaled_value, saturated, output ready);
endinterface

`default_nettype wire

/* sv/pls_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module pls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* sv/piecewise_linear_sensor_scaler_unit.sv */
// A load request writes the table and leaves the unit idle; the next request is taken in the
// following cycle. A convert request runs the bin search and then the bit-serial multiply and
// divide, and no new request is taken until its response is in the output register.
// Early exits (below the first bin, last bin, flat segment) skip the multiply and divide.
// Reset is synchronous and active high; it marks every breakpoint as zero.
`default_nettype none

module piecewise_linear_sensor_scaler_unit #(
   parameter int BIN_COUNT = pls_pkg::BIN_COUNT_DEF
) (
   input wire logic clock,
   input wire logic reset,
   pls_req_if.sink   req_ch,
   pls_rsp_if.source rsp_ch
);

   import pls_pkg::*;

   localparam int BIN_W = $clog2(BIN_COUNT);
   // Wide enough to compare any request index against the table depth.
   localparam int CMP_W = ((BIN_W > IDX_W) ? BIN_W : IDX_W) + 1;
   localparam int ENT_W = $bits(entry_type);

   // The sequencer walks the search, then the serial multiply and divide.
   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_SEEK_RD  = 9'b000000010,
      S_SEEK_CHK = 9'b000000100,
      S_NEXT_RD  = 9'b000001000,
      S_NEXT_CHK = 9'b000010000,
      S_MUL      = 9'b000100000,
      S_DIV      = 9'b001000000,
      S_ADD      = 9'b010000000,
      S_DONE     = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   logic [BIN_W-1:0]     bin_ff, bin_in;
   raw_type              sample_ff, sample_in;
   raw_type              x1_ff, x1_in;
   scaled_type           y1_ff, y1_in;
   logic [RAW_W-1:0]     dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic [PROD_W-1:0]    mcand_ff, mcand_in;
   logic [RAW_W-1:0]     mplier_ff, mplier_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [RAW_W:0]       rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SUM_W-1:0]     res_ff, res_in;
   logic [BIN_COUNT-1:0] valid_ff, valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   scaled_type           rsp_value_ff, rsp_value_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   // Table memory signals.
   logic             wr_en;
   logic [CMP_W-1:0] wr_idx;
   logic [BIN_W-1:0] rd_addr;
   logic [BIN_W-1:0] nxt_idx;
   logic [ENT_W-1:0] rd_word;
   entry_type        wr_entry;
   entry_type        rd_entry;
   raw_type          ent_raw;
   scaled_type       ent_scl;

   // Datapath helpers.
   logic              req_fire;
   logic [RAW_W:0]    dx;
   logic [RAW_W:0]    dx_neg;
   logic [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0] diff_mag;
   logic [RAW_W:0]    rem_sh;
   logic              rem_ge;
   logic [SUM_W-1:0]  q_mag;
   logic [SUM_W-1:0]  q_signed;
   logic              res_ovf;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   // A load request writes the table at once; indexes past the table are dropped.
   assign wr_idx   = CMP_W'(req_ch.entry_index);
   assign wr_en    = req_fire && (req_ch.opcode == OP_LOAD) && (wr_idx < CMP_W'(BIN_COUNT));
   assign wr_entry = '{raw: req_ch.raw_point, scaled: req_ch.scaled_point};

   // The search reads the current bin; the interpolation reads the bin above it.
   assign nxt_idx = bin_ff + BIN_W'(1);
   assign rd_addr = (state_ff == S_NEXT_RD) ? nxt_idx : bin_ff;

   pls_ram #(
      .WIDTH (ENT_W),
      .DEPTH (BIN_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx[BIN_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // An entry that was never written since reset reads as zero. Writes only
   // happen in idle, so the valid bit of the addressed entry is stable here.
   assign rd_entry = entry_type'(rd_word);
   always_comb begin
      ent_raw = '0;
      ent_scl = '0;
      if (state_ff == S_NEXT_CHK) begin
         if (valid_ff[nxt_idx]) begin
            ent_raw = rd_entry.raw;
            ent_scl = rd_entry.scaled;
         end
      end else if (valid_ff[bin_ff]) begin
         ent_raw = rd_entry.raw;
         ent_scl = rd_entry.scaled;
      end
   end

   // Segment slope terms, taken when the upper breakpoint arrives.
   assign dx       = {1'b0, ent_raw} - {1'b0, x1_ff};
   assign dx_neg   = -dx;
   assign diff     = {ent_scl[SCL_W-1], ent_scl} - {y1_ff[SCL_W-1], y1_ff};
   assign diff_mag = diff[DIFF_W-1] ? -diff : diff;

   // One step of the restoring divide: bring down one dividend bit.
   assign rem_sh = {rem_ff[RAW_W-1:0], acc_ff[PROD_W-1]};
   assign rem_ge = (rem_sh >= {1'b0, dvs_ff});

   // The quotient magnitude sits in the accumulator once the divide is done.
   assign q_mag    = SUM_W'(acc_ff);
   assign q_signed = neg_ff ? -q_mag : q_mag;

   // The sum overflows 32 bits when its upper bits are not all copies of the sign.
   assign res_ovf = !((&res_ff[SUM_W-1:SCL_W-1]) || !(|res_ff[SUM_W-1:SCL_W-1]));

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      sample_in    = sample_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;

      if (wr_en) begin
         valid_in[wr_idx[BIN_W-1:0]] = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_ch.opcode == OP_CONVERT)) begin
               sample_in = req_ch.sample;
               bin_in    = BIN_W'(BIN_COUNT - 1);
               state_in  = S_SEEK_RD;
            end
         end

         S_SEEK_RD: begin
            state_in = S_SEEK_CHK;
         end

         // Step down while the sample lies below this bin's raw point.
         S_SEEK_CHK: begin
            if ((bin_ff != '0) && (sample_ff < ent_raw)) begin
               bin_in   = bin_ff - BIN_W'(1);
               state_in = S_SEEK_RD;
            end else begin
               x1_in = ent_raw;
               y1_in = ent_scl;
               if (((bin_ff == '0) && (sample_ff < ent_raw)) ||
                   (bin_ff == BIN_W'(BIN_COUNT - 1))) begin
                  // Below the table or on the last bin: the bin value stands.
                  res_in   = {{(SUM_W-SCL_W){ent_scl[SCL_W-1]}}, ent_scl};
                  state_in = S_DONE;
               end else begin
                  state_in = S_NEXT_RD;
               end
            end
         end

         S_NEXT_RD: begin
            state_in = S_NEXT_CHK;
         end

         S_NEXT_CHK: begin
            if (dx == '0) begin
               // A flat segment would divide by zero; the lower value stands.
               res_in   = {{(SUM_W-SCL_W){y1_ff[SCL_W-1]}}, y1_ff};
               state_in = S_DONE;
            end else begin
               neg_in    = diff[DIFF_W-1] ^ dx[RAW_W];
               dvs_in    = dx[RAW_W] ? dx_neg[RAW_W-1:0] : dx[RAW_W-1:0];
               mcand_in  = PROD_W'(diff_mag);
               mplier_in = sample_ff - x1_ff;
               acc_in    = '0;
               cnt_in    = '0;
               state_in  = S_MUL;
            end
         end

         // Shift and add, one multiplier bit per cycle.
         S_MUL: begin
            acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
            mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[RAW_W-1:1]};
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(RAW_W - 1)) begin
               cnt_in   = '0;
               rem_in   = '0;
               state_in = S_DIV;
            end
         end

         // Restoring divide, one quotient bit per cycle, shifted into acc_ff.
         S_DIV: begin
            rem_in = rem_ge ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
            acc_in = {acc_ff[PROD_W-2:0], rem_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(PROD_W - 1)) begin
               cnt_in   = '0;
               state_in = S_ADD;
            end
         end

         S_ADD: begin
            res_in   = {{(SUM_W-SCL_W){y1_ff[SCL_W-1]}}, y1_ff} + q_signed;
            state_in = S_DONE;
         end

         // Hand the result over once the output register is free.
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sat_in   = res_ovf;
               if (!res_ovf) begin
                  rsp_value_in = res_ff[SCL_W-1:0];
               end else if (res_ff[SUM_W-1]) begin
                  rsp_value_in = SCL_MIN;
               end else begin
                  rsp_value_in = SCL_MAX;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bin_ff       <= '0;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bin_ff       <= bin_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      dvs_ff       <= dvs_in;
      neg_ff       <= neg_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.scaled_value = rsp_value_ff;
   assign rsp_ch.saturated    = rsp_sat_ff;

   // A convert request always starts the bin search.
   a_convert_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_ch.opcode == OP_CONVERT)) |=> (state_ff == S_SEEK_RD))
      else $error("convert request did not start the bin search");

   // The search only ever stays on a bin or moves one bin down.
   a_search_down: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEEK_CHK) |=>
         ((bin_ff == $past(bin_ff)) || (bin_ff == $past(bin_ff) - BIN_W'(1))))
      else $error("bin search moved upward or skipped a bin");

   // The partial remainder stays below the divisor through the divide.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < {1'b0, dvs_ff}))
      else $error("divide remainder reached the divisor");

   // A clamped result is one of the two range limits.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |->
         ((rsp_value_ff == SCL_MAX) || (rsp_value_ff == SCL_MIN)))
      else $error("saturated result is not a range limit");

endmodule

`default_nettype wire
